// ===== rtl/crfdb_pkg.sv =====
// types, constants and codes shared by the framebuffer fill engine
package crfdb_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 320;
	localparam int unsigned MAX_HEIGHT_DEF = 240;

	localparam int XW       = 9;
	localparam int YW       = 8;
	localparam int CW       = 16;
	localparam int OPW      = 3;
	localparam int SW       = 16;
	localparam int AWW      = 17;
	localparam int CFG_IDXW = 1;
	localparam int CFG_DW   = 9;

	localparam logic [XW-1:0] AREA_W_RST = 9'd320;
	localparam logic [YW-1:0] AREA_H_RST = 8'd240;

	localparam logic [CFG_IDXW-1:0] CFG_AREA_WIDTH  = 1'b0;
	localparam logic [CFG_IDXW-1:0] CFG_AREA_HEIGHT = 1'b1;

	localparam logic KIND_REGION = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	typedef enum logic [OPW-1:0] {
		OP_CLEAR = 3'd0,
		OP_SET   = 3'd1,
		OP_FILL  = 3'd2,
		OP_FLUSH = 3'd3,
		OP_READ  = 3'd4
	} op_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLIP,
		ST_START,
		ST_FILL,
		ST_READ,
		ST_RDATA
	} state_t;

	typedef struct packed {
		logic [OPW-1:0]       opcode;
		logic signed [SW-1:0] pos_x;
		logic signed [SW-1:0] pos_y;
		logic signed [SW-1:0] rect_width;
		logic signed [SW-1:0] rect_height;
		logic [CW-1:0]        pixel_color;
	} in_item_t;

	typedef struct packed {
		logic          result_kind;
		logic [XW-1:0] region_left;
		logic [YW-1:0] region_top;
		logic [XW-1:0] region_right;
		logic [YW-1:0] region_bottom;
		logic [CW-1:0] read_color;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic clip;
		logic start;
		logic grow;
		logic step;
		logic load_read;
		logic load_flush;
	} cmd_t;

	typedef struct packed {
		logic [OPW-1:0] op;
		logic           hit;
		logic           last;
		logic           box_valid;
	} sts_t;

endpackage

// ===== rtl/crfdb_ctrl.sv =====
// controller state machine of the framebuffer fill engine
module crfdb_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [crfdb_pkg::OPW-1:0]     in_op,
	input  logic                          out_busy,
	input  crfdb_pkg::sts_t               sts,
	output logic                          in_stall,
	output crfdb_pkg::cmd_t               cmd
);

	crfdb_pkg::state_t state_q;
	crfdb_pkg::state_t state_d;
	logic              result_op;

	assign result_op = (in_op == crfdb_pkg::OP_FLUSH) || (in_op == crfdb_pkg::OP_READ);
	assign in_stall  = (state_q != crfdb_pkg::ST_IDLE) || (out_busy && result_op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crfdb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			crfdb_pkg::ST_IDLE: begin
				if (in_valid && !in_stall) state_d = crfdb_pkg::ST_CLIP;
			end
			crfdb_pkg::ST_CLIP: begin
				case (sts.op)
					crfdb_pkg::OP_CLEAR, crfdb_pkg::OP_SET,
					crfdb_pkg::OP_FILL, crfdb_pkg::OP_READ: state_d = crfdb_pkg::ST_START;
					default: state_d = crfdb_pkg::ST_IDLE;
				endcase
			end
			crfdb_pkg::ST_START: begin
				if (!sts.hit) state_d = crfdb_pkg::ST_IDLE;
				else if (sts.op == crfdb_pkg::OP_READ) state_d = crfdb_pkg::ST_READ;
				else state_d = crfdb_pkg::ST_FILL;
			end
			crfdb_pkg::ST_FILL: begin
				if (sts.last) state_d = crfdb_pkg::ST_IDLE;
			end
			crfdb_pkg::ST_READ: state_d = crfdb_pkg::ST_RDATA;
			crfdb_pkg::ST_RDATA: state_d = crfdb_pkg::ST_IDLE;
			default: state_d = crfdb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			crfdb_pkg::ST_IDLE: begin
				cmd.accept = in_valid && !in_stall;
			end
			crfdb_pkg::ST_CLIP: begin
				cmd.clip       = 1'b1;
				cmd.load_flush = (sts.op == crfdb_pkg::OP_FLUSH) && sts.box_valid;
			end
			crfdb_pkg::ST_START: begin
				cmd.start     = 1'b1;
				cmd.grow      = sts.hit && (sts.op != crfdb_pkg::OP_READ);
				cmd.load_read = !sts.hit && (sts.op == crfdb_pkg::OP_READ);
			end
			crfdb_pkg::ST_FILL: begin
				cmd.step = 1'b1;
			end
			crfdb_pkg::ST_READ: begin
				cmd = '0;
			end
			crfdb_pkg::ST_RDATA: begin
				cmd.load_read = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/crfdb_dp.sv =====
// datapath of the framebuffer fill engine: clipping, address walk, pixel memory, dirty box
module crfdb_dp #(
	parameter int unsigned MAX_WIDTH  = crfdb_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = crfdb_pkg::MAX_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [crfdb_pkg::CFG_IDXW-1:0]     cfg_index,
	input  logic [crfdb_pkg::CFG_DW-1:0]       cfg_data,
	input  crfdb_pkg::in_item_t                in_item,
	input  crfdb_pkg::cmd_t                    cmd,
	input  logic                               out_stall,
	output crfdb_pkg::sts_t                    sts,
	output logic                               out_valid,
	output crfdb_pkg::out_item_t               out_item
);

	localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int XW = crfdb_pkg::XW;
	localparam int YW = crfdb_pkg::YW;
	localparam int SW = crfdb_pkg::SW;

	logic [XW-1:0] area_w_q;
	logic [YW-1:0] area_h_q;
	logic [XW-1:0] eff_w;
	logic [YW-1:0] eff_h;

	logic [crfdb_pkg::OPW-1:0] op_q;
	logic signed [SW-1:0]      x_q, y_q, rw_q, rh_q;
	logic [crfdb_pkg::CW-1:0]  color_q;

	logic signed [SW:0] rx, ry, rw, rh, ex, ey;
	logic signed [SW:0] x0c, y0c, x1c, y1c, wlim, hlim;
	logic               hit_c;

	logic          hit_q;
	logic [XW-1:0] x0_q, x1_q, xc_q;
	logic [YW-1:0] y0_q, y1_q, yc_q;
	logic [crfdb_pkg::AWW-1:0] base_q;
	logic [crfdb_pkg::AWW-1:0] addr17;
	logic [AW+crfdb_pkg::AWW-1:0] addr_ext;
	logic [AW-1:0] mem_addr;
	logic          row_end;

	logic [crfdb_pkg::CW-1:0] mem [Depth];
	logic [crfdb_pkg::CW-1:0] rdata_q;

	logic          box_valid_q;
	logic [XW-1:0] box_left_q, box_right_q;
	logic [YW-1:0] box_top_q, box_bottom_q;

	logic                 out_valid_q;
	crfdb_pkg::out_item_t out_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_w_q <= crfdb_pkg::AREA_W_RST;
			area_h_q <= crfdb_pkg::AREA_H_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				crfdb_pkg::CFG_AREA_WIDTH:  area_w_q <= cfg_data;
				crfdb_pkg::CFG_AREA_HEIGHT: area_h_q <= cfg_data[YW-1:0];
				default: ;
			endcase
		end
	end

	assign eff_w = (32'(area_w_q) > MAX_WIDTH) ? XW'(MAX_WIDTH) : area_w_q;
	assign eff_h = (32'(area_h_q) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : area_h_q;

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= in_item.opcode;
			x_q     <= in_item.pos_x;
			y_q     <= in_item.pos_y;
			rw_q    <= in_item.rect_width;
			rh_q    <= in_item.rect_height;
			color_q <= in_item.pixel_color;
		end
	end

	// clipping against the effective area
	assign wlim = {8'b0, eff_w};
	assign hlim = {9'b0, eff_h};

	always_comb begin
		case (op_q)
			crfdb_pkg::OP_CLEAR: begin
				rx = '0;
				ry = '0;
				rw = wlim;
				rh = hlim;
			end
			crfdb_pkg::OP_FILL: begin
				rx = {x_q[SW-1], x_q};
				ry = {y_q[SW-1], y_q};
				rw = {rw_q[SW-1], rw_q};
				rh = {rh_q[SW-1], rh_q};
			end
			default: begin
				rx = {x_q[SW-1], x_q};
				ry = {y_q[SW-1], y_q};
				rw = 17'sd1;
				rh = 17'sd1;
			end
		endcase
	end

	assign ex    = rx + rw;
	assign ey    = ry + rh;
	assign x0c   = (rx < 17'sd0) ? 17'sd0 : rx;
	assign y0c   = (ry < 17'sd0) ? 17'sd0 : ry;
	assign x1c   = (ex > wlim) ? wlim : ex;
	assign y1c   = (ey > hlim) ? hlim : ey;
	assign hit_c = (rw > 17'sd0) && (rh > 17'sd0) && (x0c < x1c) && (y0c < y1c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.clip) begin
			hit_q <= hit_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clip) begin
			x0_q <= x0c[XW-1:0];
			x1_q <= x1c[XW-1:0];
			y0_q <= y0c[YW-1:0];
			y1_q <= y1c[YW-1:0];
		end
	end

	// raster walk
	assign row_end = (xc_q == x1_q - 9'd1);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			base_q <= crfdb_pkg::AWW'(y0_q * eff_w);
			xc_q   <= x0_q;
			yc_q   <= y0_q;
		end else if (cmd.step) begin
			if (row_end) begin
				xc_q   <= x0_q;
				yc_q   <= yc_q + 8'd1;
				base_q <= base_q + crfdb_pkg::AWW'(eff_w);
			end else begin
				xc_q <= xc_q + 9'd1;
			end
		end
	end

	assign addr17   = base_q + crfdb_pkg::AWW'(xc_q);
	assign addr_ext = (AW + crfdb_pkg::AWW)'(addr17);
	assign mem_addr = addr_ext[AW-1:0];

	// pixel memory
	always_ff @(posedge clk) begin
		if (cmd.step) mem[mem_addr] <= color_q;
		rdata_q <= mem[mem_addr];
	end

	// dirty box
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_valid_q  <= 1'b0;
			box_left_q   <= '0;
			box_top_q    <= '0;
			box_right_q  <= '0;
			box_bottom_q <= '0;
		end else if (cmd.load_flush) begin
			box_valid_q  <= 1'b0;
			box_left_q   <= '0;
			box_top_q    <= '0;
			box_right_q  <= '0;
			box_bottom_q <= '0;
		end else if (cmd.grow) begin
			box_valid_q <= 1'b1;
			if (!box_valid_q || x0_q < box_left_q) box_left_q <= x0_q;
			if (!box_valid_q || y0_q < box_top_q) box_top_q <= y0_q;
			if (!box_valid_q || x1_q - 9'd1 > box_right_q) box_right_q <= x1_q - 9'd1;
			if (!box_valid_q || y1_q - 8'd1 > box_bottom_q) box_bottom_q <= y1_q - 8'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_read || cmd.load_flush) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_flush) begin
			out_q.result_kind   <= crfdb_pkg::KIND_REGION;
			out_q.region_left   <= box_left_q;
			out_q.region_top    <= box_top_q;
			out_q.region_right  <= box_right_q;
			out_q.region_bottom <= box_bottom_q;
			out_q.read_color    <= '0;
		end else if (cmd.load_read) begin
			out_q.result_kind   <= crfdb_pkg::KIND_READ;
			out_q.region_left   <= '0;
			out_q.region_top    <= '0;
			out_q.region_right  <= '0;
			out_q.region_bottom <= '0;
			out_q.read_color    <= hit_q ? rdata_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign sts.op        = op_q;
	assign sts.hit       = hit_q;
	assign sts.last      = row_end && (yc_q == y1_q - 8'd1);
	assign sts.box_valid = box_valid_q;

endmodule

// ===== rtl/clipped_rect_fill_dirty_box.sv =====
// top level of the RGB565 framebuffer fill engine with dirty box tracking
// one item at a time; flush: CLIP loads the box into the output, only if it is not empty, then back to idle
// set pixel, clear and fill rect: CLIP, START, then one written pixel per FILL step (one memory write port)
// read pixel: CLIP, START, READ, then RDATA loads the result; outside the area START loads colour 0
// flush and read wait at the input while an earlier result is still stalled
// async reset empties the box, sets the area to 320 x 240; pixel memory is not cleared
module clipped_rect_fill_dirty_box #(
	parameter int unsigned MAX_WIDTH  = crfdb_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = crfdb_pkg::MAX_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  crfdb_pkg::in_item_t                in_item,
	output logic                               out_valid,
	input  logic                               out_stall,
	output crfdb_pkg::out_item_t               out_item,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [crfdb_pkg::CFG_IDXW-1:0]     cfg_index,
	input  logic [crfdb_pkg::CFG_DW-1:0]       cfg_data
);

	crfdb_pkg::cmd_t cmd;
	crfdb_pkg::sts_t sts;
	logic            out_busy;

	assign cfg_ready = 1'b1;
	assign out_busy  = out_valid && out_stall;

	crfdb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_item.opcode),
		.out_busy (out_busy),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	crfdb_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.out_stall (out_stall),
		.sts       (sts),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("item accepted while previous item still in work");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_read || cmd.load_flush) |-> (!out_valid || !out_stall))
		else $error("result loaded over an untaken result");

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_flush |=> !sts.box_valid)
		else $error("dirty box not emptied by flush");

	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.result_kind == crfdb_pkg::KIND_REGION) |->
		(out_item.region_left <= out_item.region_right &&
		 out_item.region_top <= out_item.region_bottom))
		else $error("flush region corners out of order");

endmodule
